// ===== rtl/bcc_pkg.sv =====
// Shared constants, types and the carrier magnitude table of the BPSK correlator.
`timescale 1ns / 1ps

package bcc_pkg;

	// Received sample and carrier formats.
	localparam int SAMPLE_W = 16;
	localparam int CARR_W = 16;
	localparam int MAG_W = CARR_W - 1;

	// Carrier table: full-cycle depth, folded onto a quarter wave.
	// The quarter-wave end point is kept apart so the table stays a power of two deep.
	localparam int SINE_DEPTH = 1024;
	localparam int IDX_W = $clog2(SINE_DEPTH);
	localparam int QTR_W = IDX_W - 2;
	localparam int QTR = SINE_DEPTH / 4;
	localparam int MAG_DEPTH = QTR;
	localparam int MAG_AW = $clog2(QTR + 1);

	// Configuration registers.
	localparam int PHASE_W = 32;
	localparam int GAIN_W = 16;
	localparam int SPB_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIT = 2'd2;

	localparam logic [PHASE_W-1:0] RST_PHASE_STEP = 32'd42949673;
	localparam logic [GAIN_W-1:0] RST_GAIN = 16'd256;
	localparam logic [SPB_W-1:0] RST_SAMPLES_PER_BIT = 11'd100;

	// Bit period counter.
	localparam int CNT_W = 10;
	localparam logic [SPB_W-1:0] MAX_BIT_LEN = 11'd1024;

	// Arithmetic widths.
	localparam int SC_W = SAMPLE_W + CARR_W;
	localparam int FULL_W = SC_W + GAIN_W + 1;
	localparam int PROD_SHIFT = SAMPLE_W + 7;
	localparam int PROD_W = 24;
	localparam int SUM_W = 40;

	// Queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	// Q30 Taylor coefficients of sin(pi/2 * t).
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] COEF_C1 = 64'd1686629713;
	localparam logic [63:0] COEF_C3 = 64'd693598669;
	localparam logic [63:0] COEF_C5 = 64'd85569305;
	localparam logic [63:0] COEF_C7 = 64'd5026994;
	localparam logic [63:0] COEF_C9 = 64'd172272;

	typedef logic [MAG_W-1:0] mag_rom_t [MAG_DEPTH];

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [GAIN_W-1:0] gain;
		logic [SPB_W-1:0] samples_per_bit;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic neg;
		logic [MAG_AW-1:0] addr;
		logic last;
	} q_entry_t;

	// Magnitude of sin(pi/2 * a / QTR), rounded to Q15.
	function automatic logic [MAG_W-1:0] mag_entry(int a);
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] h;
		logic [63:0] s;
		logic [63:0] mag;
		t = 64'(a) << (30 - QTR_W);
		if (t > Q30_ONE) begin
			t = Q30_ONE;
		end
		u = (t * t) >> 30;
		h = COEF_C9;
		h = COEF_C7 - ((u * h) >> 30);
		h = COEF_C5 - ((u * h) >> 30);
		h = COEF_C3 - ((u * h) >> 30);
		h = COEF_C1 - ((u * h) >> 30);
		s = (t * h) >> 30;
		mag = (s + 64'd16384) >> 15;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return mag[MAG_W-1:0];
	endfunction

	function automatic mag_rom_t build_mag_rom();
		mag_rom_t rom;
		for (int a = 0; a < MAG_DEPTH; a++) begin
			rom[a] = mag_entry(a);
		end
		return rom;
	endfunction

	localparam mag_rom_t MAG_ROM = build_mag_rom();
	localparam logic [MAG_W-1:0] MAG_PEAK = mag_entry(QTR);

endpackage

// ===== rtl/bcc_front.sv =====
// Front part: carrier phase accumulator, table address folding and bit period counter.
`timescale 1ns / 1ps

module bcc_front
	import bcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     push,
	input  logic signed [SAMPLE_W-1:0] sample,
	output q_entry_t entry
);

	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx;
	logic [QTR_W-1:0] r;
	logic [SPB_W-1:0] len;
	logic [SPB_W-1:0] cnt_inc;
	logic last;

	// The table index is the top of the phase before it advances.
	assign idx = phase_q[PHASE_W-1 -: IDX_W];
	assign r = idx[QTR_W-1:0];

	always_comb begin
		if (cfg.samples_per_bit == '0) begin
			len = SPB_W'(1);
		end else if (cfg.samples_per_bit > MAX_BIT_LEN) begin
			len = MAX_BIT_LEN;
		end else begin
			len = cfg.samples_per_bit;
		end
	end

	assign cnt_inc = SPB_W'(count_q) + SPB_W'(1);
	assign last = (cnt_inc >= len);

	// Odd quadrants read the quarter wave backward, the upper half is negated.
	always_comb begin
		entry.sample = sample;
		entry.neg = idx[IDX_W-1];
		entry.addr = idx[IDX_W-2] ? (MAG_AW'(QTR) - MAG_AW'(r)) : MAG_AW'(r);
		entry.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (push) begin
			phase_q <= phase_q + cfg.phase_step;
			count_q <= last ? '0 : cnt_inc[CNT_W-1:0];
		end
	end

	a_count_clears_at_bit_end: assert property (@(posedge clk) disable iff (!arst_n)
		push && last |=> count_q == '0)
		else $error("bit counter did not clear after the last sample of a bit");

endmodule

// ===== rtl/bcc_queue.sv =====
// Short register queue that decouples the front from the back.
`timescale 1ns / 1ps

module bcc_queue
	import bcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wr_entry,
	input  logic     pop,
	output q_entry_t head,
	output logic     full,
	output logic     empty
);

	q_entry_t mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue fill count exceeds its depth");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("request written into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("request read from an empty queue");

endmodule

// ===== rtl/bcc_back.sv =====
// Back part: carrier lookup, two multiplier stages, saturation and the integrate-and-dump.
`timescale 1ns / 1ps

module bcc_back
	import bcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  q_entry_t head,
	input  logic     empty,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_stall,
	output logic signed [PROD_W-1:0] product,
	output logic signed [SUM_W-1:0] running_sum,
	output logic     decision,
	output logic     bit_end
);

	localparam logic signed [PROD_W-1:0] PROD_MAX = {1'b0, {(PROD_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] PROD_MIN = {1'b1, {(PROD_W-1){1'b0}}};

	logic en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [CARR_W-1:0] carrier_s1;
	logic signed [SC_W-1:0] sc_s2;
	logic signed [FULL_W-1:0] full_s3;
	logic signed [PROD_W-1:0] prod_s4;

	logic out_valid_q;
	logic signed [PROD_W-1:0] product_q;
	logic signed [SUM_W-1:0] running_sum_q;
	logic decision_q;
	logic bit_end_q;
	logic signed [SUM_W-1:0] integ_q;

	logic [MAG_W-1:0] mag_rd;
	logic signed [CARR_W-1:0] mag_ext;
	logic signed [CARR_W-1:0] carrier_d;
	logic signed [SC_W-1:0] sc_d;
	logic signed [FULL_W-1:0] full_d;
	logic top_same;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [SUM_W-1:0] sum_d;

	// The whole pipeline holds while a finished result waits at the output.
	assign en = !out_valid_q || !out_stall;
	assign pop = en && !empty;

	// The quarter-wave peak sits just past the end of the table.
	assign mag_rd = (head.addr == MAG_AW'(QTR)) ? MAG_PEAK : MAG_ROM[head.addr[QTR_W-1:0]];
	assign mag_ext = $signed({1'b0, mag_rd});
	assign carrier_d = head.neg ? -mag_ext : mag_ext;
	assign sc_d = sample_s1 * carrier_s1;
	assign full_d = sc_s2 * $signed({1'b0, cfg.gain});

	// Dropping the low bits floors the value; the rest saturates when its top disagrees.
	assign top_same = (full_s3[FULL_W-1:PROD_SHIFT+PROD_W-1] == '0)
		|| (full_s3[FULL_W-1:PROD_SHIFT+PROD_W-1] == '1);

	always_comb begin
		if (top_same) begin
			prod_d = full_s3[PROD_SHIFT+PROD_W-1:PROD_SHIFT];
		end else if (full_s3[FULL_W-1]) begin
			prod_d = PROD_MIN;
		end else begin
			prod_d = PROD_MAX;
		end
	end

	assign sum_d = integ_q + SUM_W'(prod_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
			integ_q <= '0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
			if (v_s4) begin
				integ_q <= last_s4 ? '0 : sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= head.sample;
			carrier_s1 <= carrier_d;
			last_s1 <= head.last;
			sc_s2 <= sc_d;
			last_s2 <= last_s1;
			full_s3 <= full_d;
			last_s3 <= last_s2;
			prod_s4 <= prod_d;
			last_s4 <= last_s3;
			product_q <= prod_s4;
			running_sum_q <= sum_d;
			decision_q <= !sum_d[SUM_W-1] && (sum_d != '0);
			bit_end_q <= last_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign product = product_q;
	assign running_sum = running_sum_q;
	assign decision = decision_q;
	assign bit_end = bit_end_q;

	a_dump_after_bit_end: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 && last_s4 |=> integ_q == '0)
		else $error("integrator not cleared after the last sample of a bit");

	a_decision_matches_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && decision_q |-> !running_sum_q[SUM_W-1] && running_sum_q != '0)
		else $error("decision bit disagrees with the running sum");

endmodule

// ===== rtl/bpsk_coherent_correlator_core.sv =====
// Top level of the coherent BPSK correlation demodulator.
//
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   sample
// output    out        out_valid/out_stall product, running_sum, decision, bit_end
// config    in         cfg_wr_en           cfg_index, cfg_wdata
//
// One sample is taken per clock while in_stall is low, and one result per sample
// leaves per clock while out_stall is low. Each result passes a queue entry, the carrier
// table read, the sample-by-carrier and gain multipliers, saturation, then the integrator.
// Reset loads the register defaults and clears phase, bit counter and integrator.
// in_stall rises when the four-entry queue is full; out_stall freezes the back pipeline.
`timescale 1ns / 1ps

module bpsk_coherent_correlator_core
	import bcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [PROD_W-1:0] product,
	output logic signed [SUM_W-1:0] running_sum,
	output logic decision,
	output logic bit_end,
	input  logic cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	q_entry_t front_entry;
	q_entry_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= RST_PHASE_STEP;
			cfg_q.gain <= RST_GAIN;
			cfg_q.samples_per_bit <= RST_SAMPLES_PER_BIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PHASE_STEP: cfg_q.phase_step <= cfg_wdata[PHASE_W-1:0];
				REG_GAIN: cfg_q.gain <= cfg_wdata[GAIN_W-1:0];
				REG_SAMPLES_PER_BIT: cfg_q.samples_per_bit <= cfg_wdata[SPB_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign push = in_valid && !full;

	bcc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.sample (sample),
		.entry  (front_entry)
	);

	bcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (front_entry),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	bcc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.product     (product),
		.running_sum (running_sum),
		.decision    (decision),
		.bit_end     (bit_end)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the coherent BPSK correlation demodulator core.
`timescale 1ns / 1ps

module tb_top;
	import bcc_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 10;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int MAX_REPORTS = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [PROD_W-1:0] product;
		logic signed [SUM_W-1:0] running_sum;
		logic decision;
		logic bit_end;
	} corr_result_t;

	// Tracks register copies and correlator state, and holds the results still owed.
	class demod_scoreboard;
		logic [PHASE_W-1:0] step_r;
		logic [GAIN_W-1:0] gain_r;
		logic [SPB_W-1:0] spb_r;
		logic [PHASE_W-1:0] phase_acc;
		logic [CNT_W-1:0] bit_cnt;
		logic [SUM_W-1:0] integ;
		int carrier_lut[SINE_DEPTH];
		corr_result_t owed_results[$];
		int mismatches;

		function new();
			step_r = RST_PHASE_STEP;
			gain_r = RST_GAIN;
			spb_r = RST_SAMPLES_PER_BIT;
			phase_acc = '0;
			bit_cnt = '0;
			integ = '0;
			mismatches = 0;
			for (int k = 0; k < SINE_DEPTH; k++) begin
				carrier_lut[k] = sine_entry(k);
			end
		endfunction

		// Quadrant folding plus an odd polynomial in Q30, rounded to Q15.
		function int sine_entry(int k);
			logic [63:0] pos;
			logic [63:0] quad;
			logic [63:0] rem;
			logic [63:0] t;
			logic [63:0] u;
			logic [63:0] h;
			logic [63:0] s;
			logic [63:0] mag;
			pos = 64'(4 * k);
			quad = pos / SINE_DEPTH;
			rem = pos % SINE_DEPTH;
			t = (rem << 30) / SINE_DEPTH;
			if (quad[0]) begin
				t = Q30_ONE - t;
			end
			u = (t * t) >> 30;
			h = COEF_C9;
			h = COEF_C7 - ((u * h) >> 30);
			h = COEF_C5 - ((u * h) >> 30);
			h = COEF_C3 - ((u * h) >> 30);
			h = COEF_C1 - ((u * h) >> 30);
			s = (t * h) >> 30;
			mag = (s + 64'd16384) >> 15;
			if (mag > 64'd32767) begin
				mag = 64'd32767;
			end
			return (quad >= 2) ? -int'(mag) : int'(mag);
		endfunction

		function int current_carrier();
			logic [63:0] idx;
			idx = (64'(phase_acc) * 64'(SINE_DEPTH)) >> 32;
			return carrier_lut[idx % SINE_DEPTH];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_PHASE_STEP: begin
					step_r = d[PHASE_W-1:0];
				end
				REG_GAIN: begin
					gain_r = d[GAIN_W-1:0];
				end
				REG_SAMPLES_PER_BIT: begin
					spb_r = d[SPB_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] s);
			longint full;
			logic [SPB_W-1:0] len;
			logic last;
			corr_result_t r;
			full = longint'(s) * longint'(current_carrier()) * longint'(gain_r);
			full = full >>> PROD_SHIFT;
			if (full > 64'sd8388607) begin
				full = 64'sd8388607;
			end else if (full < -64'sd8388608) begin
				full = -64'sd8388608;
			end
			integ = integ + SUM_W'(full);
			len = spb_r;
			if (len == 0) begin
				len = SPB_W'(1);
			end
			if (len > MAX_BIT_LEN) begin
				len = MAX_BIT_LEN;
			end
			// A shortened bit length takes effect at once, even past the current count.
			last = (32'(bit_cnt) + 1) >= 32'(len);
			r.product = full[PROD_W-1:0];
			r.running_sum = integ;
			r.decision = ($signed(integ) > 0);
			r.bit_end = last;
			owed_results.push_back(r);
			phase_acc = phase_acc + step_r;
			if (last) begin
				bit_cnt = '0;
				integ = '0;
			end else begin
				bit_cnt = bit_cnt + 1'b1;
			end
		endfunction

		function void check_result(logic signed [PROD_W-1:0] p, logic signed [SUM_W-1:0] sum,
				logic dec, logic be);
			corr_result_t r;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected result: product %0d sum %0d decision %0b bit_end %0b",
						p, sum, dec, be);
				end
				return;
			end
			r = owed_results.pop_front();
			if (r.product !== p || r.running_sum !== sum || r.decision !== dec
					|| r.bit_end !== be) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch: product %0d/%0d sum %0d/%0d ",
						r.product, p, r.running_sum, sum,
						"decision %0b/%0b bit_end %0b/%0b (exp/got)",
						r.decision, dec, r.bit_end, be);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic out_valid;
	logic out_stall;
	logic signed [PROD_W-1:0] product;
	logic signed [SUM_W-1:0] running_sum;
	logic decision;
	logic bit_end;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	demod_scoreboard sb;
	int in_quiet = 0;
	int out_quiet = 0;
	int idle_cycles = 0;
	logic polarity = 1'b0;

	bpsk_coherent_correlator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.product(product),
		.running_sum(running_sum),
		.decision(decision),
		.bit_end(bit_end),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mostly short gaps, a few long ones, and now and then a stretch with none.
	function automatic int pick_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] junk_above(logic [CFG_DATA_W-1:0] v, int w);
		return ($urandom() << w) | v;
	endfunction

	// Modulated samples follow the local carrier with a data polarity that can flip on bit starts.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic modulated);
		int v;
		int r;
		if (!modulated || $urandom_range(0, 9) == 0) begin
			r = $urandom_range(0, 15);
			if (r == 0) begin
				return -16'sd32768;
			end
			if (r == 1) begin
				return 16'sd32767;
			end
			return SAMPLE_W'($urandom_range(0, 65535));
		end
		if (sb.bit_cnt == 0 && $urandom_range(0, 1) == 1) begin
			polarity = !polarity;
		end
		v = (sb.current_carrier() * int'($urandom_range(4096, 32767))) >>> 15;
		v = v + int'($urandom_range(0, 1024)) - 512;
		if (polarity) begin
			v = -v;
		end
		if (v > 32767) begin
			v = 32767;
		end else if (v < -32768) begin
			v = -32768;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic drive_sample(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		gap = pick_gap(in_quiet);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.take_sample(s);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, d);
	endtask

	// Stop sending and let every outstanding result come back before touching registers.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.owed_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (out_stall) begin
				out_stall <= 1'b0;
				hold = $urandom_range(0, 6);
			end else begin
				hold = pick_gap(out_quiet);
				if (hold > 0) begin
					out_stall <= 1'b1;
					hold--;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(product, running_sum, decision, bit_end);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [PHASE_W-1:0] step_v;
		logic [GAIN_W-1:0] gain_v;
		logic [SPB_W-1:0] spb_v;
		logic modulated;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_PHASE_STEP;
		cfg_wdata = '0;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults, then the sample extremes.
		drive_sample(16'sd32767);
		drive_sample(-16'sd32768);
		drive_sample(16'sd0);
		drive_sample(-16'sd1);
		drive_sample(16'sd1);
		wait_idle();

		// Quarter-cycle steps put the carrier on its zero crossings and peaks; full gain takes the product near full scale.
		// A zero bit length ends a bit on every sample.
		write_reg(REG_GAIN, junk_above(32'hFFFF, GAIN_W));
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		write_reg(REG_SAMPLES_PER_BIT, junk_above(32'd0, SPB_W));
		write_reg(REG_UNUSED, $urandom());
		drive_sample(16'sd32767);
		drive_sample(16'sd32767);
		drive_sample(-16'sd32768);
		drive_sample(-16'sd32768);
		drive_sample(-16'sd32768);
		drive_sample(-16'sd32768);
		drive_sample(16'sd32767);
		drive_sample(16'sd32767);
		drive_sample(16'sh5555);
		drive_sample(16'shAAAA);
		wait_idle();

		// Zero gain, the largest phase step and a bit length beyond the counter's range.
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_GAIN, junk_above(32'h0, GAIN_W));
		write_reg(REG_SAMPLES_PER_BIT, junk_above(32'd2047, SPB_W));
		drive_sample(16'sd32767);
		drive_sample(-16'sd32768);
		drive_sample(-16'sd1);
		drive_sample(16'sd1);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: step_v = '0;
				1: step_v = '1;
				2: step_v = RST_PHASE_STEP;
				3: step_v = 32'h8000_0000;
				default: step_v = $urandom();
			endcase
			case ($urandom_range(0, 4))
				0: gain_v = '0;
				1: gain_v = '1;
				2: gain_v = RST_GAIN;
				default: gain_v = GAIN_W'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 9))
				0: spb_v = 11'd0;
				1: spb_v = 11'd1;
				2: spb_v = MAX_BIT_LEN;
				3: spb_v = 11'd2047;
				4: spb_v = SPB_W'($urandom_range(1025, 2047));
				5, 6, 7: spb_v = SPB_W'($urandom_range(2, 20));
				default: spb_v = SPB_W'($urandom_range(1, 1023));
			endcase
			// A long bit followed by a short one ends a bit in the middle of its count.
			if (ph == 0) begin
				spb_v = MAX_BIT_LEN;
			end else if (ph == 1) begin
				spb_v = 11'd3;
			end
			write_reg(REG_PHASE_STEP, step_v);
			write_reg(REG_GAIN, junk_above(32'(gain_v), GAIN_W));
			write_reg(REG_SAMPLES_PER_BIT, junk_above(32'(spb_v), SPB_W));
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_UNUSED, $urandom());
			end
			modulated = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				drive_sample(pick_sample(modulated));
			end
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
